// File: rtl/pidaw_pkg.sv
// Shared types, codes and the microcode program of the PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

    // Width of the microcode step counter
    localparam int PC_W = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd4;

    // Register values after reset
    localparam int GAIN_P_RESET         = 19661;
    localparam int GAIN_I_RESET         = 3277;
    localparam int GAIN_D_RESET         = 6554;
    localparam int INTEGRAL_LIMIT_RESET = 32768;
    localparam int OUTPUT_LIMIT_RESET   = 32768;

    // Program step numbers that are jump targets
    localparam logic [PC_W-1:0] STEP_FINISH = 4'd8;
    localparam logic [PC_W-1:0] STEP_CLEAR  = 4'd9;

    typedef enum logic [1:0] {
        UNIT_NONE = 2'd0,
        UNIT_MUL  = 2'd1,
        UNIT_DIV  = 2'd2
    } t_unit_op;

    typedef enum logic [2:0] {
        X_ERR    = 3'd0,
        X_GAIN_P = 3'd1,
        X_GAIN_I = 3'd2,
        X_GAIN_D = 3'd3,
        X_TMP    = 3'd4
    } t_xsel;

    typedef enum logic [1:0] {
        Y_DT    = 2'd0,
        Y_ERR   = 2'd1,
        Y_INTEG = 2'd2,
        Y_TMP   = 2'd3
    } t_ysel;

    typedef enum logic [3:0] {
        ALU_NOP       = 4'd0,
        ALU_INT_ADD   = 4'd1,
        ALU_INT_CLAMP = 4'd2,
        ALU_ACC_LOAD  = 4'd3,
        ALU_ACC_ADD   = 4'd4,
        ALU_DIFF      = 4'd5,
        ALU_TMP_LOAD  = 4'd6,
        ALU_FINISH    = 4'd7,
        ALU_CLEAR     = 4'd8
    } t_alu_op;

    typedef enum logic [1:0] {
        JMP_NONE     = 2'd0,
        JMP_CLEAR    = 2'd1,
        JMP_SHORT_DT = 2'd2
    } t_jump;

    // One microcode control word
    typedef struct packed {
        t_unit_op        unit;
        t_xsel           xsel;
        t_ysel           ysel;
        t_alu_op         alu;
        t_jump           jump;
        logic [PC_W-1:0] target;
        logic            last;
    } t_ctl_word;

    // Start strobe and operation for the shared arithmetic unit
    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    // Sequencer strobes toward the datapath
    typedef struct packed {
        logic      accept;
        logic      unit_start;
        logic      exec;
        logic      load_out;
        t_ctl_word word;
    } t_seq_ctl;

    // Datapath status toward the sequencer
    typedef struct packed {
        logic unit_done;
        logic clear_req;
        logic short_dt;
    } t_seq_stat;

    // Microcode program
    function automatic t_ctl_word rom_word(input logic [PC_W-1:0] pc);
        t_ctl_word w;
        case (pc)
            4'd0: w = '{UNIT_NONE, X_ERR,    Y_DT,    ALU_NOP,       JMP_CLEAR,    STEP_CLEAR,  1'b0};
            4'd1: w = '{UNIT_MUL,  X_ERR,    Y_DT,    ALU_INT_ADD,   JMP_NONE,     STEP_FINISH, 1'b0};
            4'd2: w = '{UNIT_NONE, X_ERR,    Y_DT,    ALU_INT_CLAMP, JMP_NONE,     STEP_FINISH, 1'b0};
            4'd3: w = '{UNIT_MUL,  X_GAIN_P, Y_ERR,   ALU_ACC_LOAD,  JMP_NONE,     STEP_FINISH, 1'b0};
            4'd4: w = '{UNIT_MUL,  X_GAIN_I, Y_INTEG, ALU_ACC_ADD,   JMP_SHORT_DT, STEP_FINISH, 1'b0};
            4'd5: w = '{UNIT_NONE, X_ERR,    Y_DT,    ALU_DIFF,      JMP_NONE,     STEP_FINISH, 1'b0};
            4'd6: w = '{UNIT_MUL,  X_GAIN_D, Y_TMP,   ALU_TMP_LOAD,  JMP_NONE,     STEP_FINISH, 1'b0};
            4'd7: w = '{UNIT_DIV,  X_TMP,    Y_DT,    ALU_ACC_ADD,   JMP_NONE,     STEP_FINISH, 1'b0};
            4'd8: w = '{UNIT_NONE, X_ERR,    Y_DT,    ALU_FINISH,    JMP_NONE,     STEP_FINISH, 1'b1};
            4'd9: w = '{UNIT_NONE, X_ERR,    Y_DT,    ALU_CLEAR,     JMP_NONE,     STEP_FINISH, 1'b1};
            default: w = '{UNIT_NONE, X_ERR, Y_DT,    ALU_CLEAR,     JMP_NONE,     STEP_FINISH, 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pidaw_arith.sv
// Shared bit-serial fixed-point multiplier and divider with saturating result.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_arith #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int TSB = FRAC_BITS + 8,
    localparam int OPW = (DATA_WIDTH > TSB) ? DATA_WIDTH : TSB,
    localparam int YW  = OPW + 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pidaw_pkg::t_unit_ctl         i_ctl,
    input  wire logic signed [DATA_WIDTH-1:0] i_x,
    input  wire logic signed [YW-1:0]         i_y,
    output logic                              o_done,
    output logic signed [DATA_WIDTH-1:0]      o_result
);

    localparam int DW = DATA_WIDTH;
    localparam int LW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(LW + 1);

    logic                 r_busy, r_fin, r_done;
    logic [CW-1:0]        r_cnt;
    pidaw_pkg::t_unit_op  r_op;
    logic                 r_neg;
    logic [OPW-1:0]       r_a;
    logic [OPW-1:0]       r_hi;
    logic [LW-1:0]        r_lo;
    logic signed [DW-1:0] r_result;

    logic [DW-1:0]    mx;
    logic [OPW-1:0]   my;
    logic [YW-1:0]    y_neg;
    logic [OPW:0]     mul_sum;
    logic [TSB:0]     trial;
    logic [TSB:0]     diff;
    logic             ge;
    logic [OPW+LW-1:0] prod;
    logic             ovf;
    logic [DW-2:0]    mval;
    logic signed [DW-1:0] post;

    assign mx    = i_x[DW-1] ? (~i_x + DW'(1)) : i_x;
    assign y_neg = ~i_y + YW'(1);
    assign my    = i_y[YW-1] ? y_neg[OPW-1:0] : i_y[OPW-1:0];

    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(OPW+1){1'b0}});
    assign trial   = {r_hi[TSB-1:0], r_lo[LW-1]};
    assign diff    = trial - {1'b0, r_a[TSB-1:0]};
    assign ge      = ~diff[TSB];
    assign prod    = {r_hi, r_lo};

    always_comb begin
        if (r_op == pidaw_pkg::UNIT_DIV) begin
            ovf  = |r_lo[LW-1:DW-1];
            mval = r_lo[DW-2:0];
        end else begin
            ovf  = |prod[OPW+LW-1:FRAC_BITS+DW-1];
            mval = prod[FRAC_BITS+DW-2:FRAC_BITS];
        end
        if (r_neg) begin
            post = ovf ? {1'b1, {(DW-1){1'b0}}} : -$signed({1'b0, mval});
        end else begin
            post = ovf ? {1'b0, {(DW-1){1'b1}}} : $signed({1'b0, mval});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(LW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op <= i_ctl.op;
            r_hi <= '0;
            if (i_ctl.op == pidaw_pkg::UNIT_DIV) begin
                r_neg <= i_x[DW-1];
                r_a   <= my;
                r_lo  <= {mx, {FRAC_BITS{1'b0}}};
            end else begin
                r_neg <= i_x[DW-1] ^ i_y[YW-1];
                r_a   <= OPW'(mx);
                r_lo  <= LW'(my);
            end
        end else if (r_busy) begin
            if (r_op == pidaw_pkg::UNIT_DIV) begin
                r_hi <= OPW'(ge ? diff[TSB-1:0] : trial[TSB-1:0]);
                r_lo <= {r_lo[LW-2:0], ge};
            end else begin
                r_hi <= mul_sum[OPW:1];
                r_lo <= {mul_sum[0], r_lo[LW-1:1]};
            end
        end
        if (r_fin) begin
            r_result <= post;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/pidaw_seq.sv
// Microcode sequencer: step counter, program ROM, jumps and handshakes.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire pidaw_pkg::t_seq_stat i_stat,
    output pidaw_pkg::t_seq_ctl       o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } t_seq_state;

    t_seq_state                   r_state, n_state;
    logic [pidaw_pkg::PC_W-1:0]   r_pc, n_pc;
    logic                         r_out_valid, n_out_valid;
    pidaw_pkg::t_ctl_word         word;
    logic                         taken;
    logic                         step_done;

    assign word = pidaw_pkg::rom_word(r_pc);

    always_comb begin
        case (word.jump)
            pidaw_pkg::JMP_CLEAR:    taken = i_stat.clear_req;
            pidaw_pkg::JMP_SHORT_DT: taken = i_stat.short_dt;
            default:                 taken = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_pc         = r_pc;
        n_out_valid  = r_out_valid;
        step_done    = 1'b0;
        o_ctl        = '0;
        o_ctl.word   = word;

        // drop the output request once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_pc         = '0;
                    n_state      = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (word.unit != pidaw_pkg::UNIT_NONE) begin
                    o_ctl.unit_start = 1'b1;
                    n_state          = S_WAIT;
                end else begin
                    o_ctl.exec = 1'b1;
                    step_done  = 1'b1;
                end
            end
            S_WAIT: begin
                if (i_stat.unit_done) begin
                    o_ctl.exec = 1'b1;
                    step_done  = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance or jump after the step's datapath operation
        if (step_done) begin
            if (word.last) begin
                n_state = S_OUT;
            end else begin
                n_pc    = taken ? word.target : r_pc + pidaw_pkg::PC_W'(1);
                n_state = S_ISSUE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/pid_antiwindup_controller_unit.sv
// Top level of the PID controller: registers, datapath and unit wiring.
`timescale 1ns / 1ps
`default_nettype none

// Single-channel PID controller with a clamped integral, signed fixed point
// with FRAC_BITS fraction bits in DATA_WIDTH bits; time_step is unsigned
// Q8.FRAC_BITS seconds. A compute request (action 0) adds error*dt to the
// integral, clamps it to +-integral_limit, forms
// gain_p*error + gain_i*integral + gain_d*(error-previous)/dt with every
// product truncated toward zero and every sum saturated, and returns that sum
// clamped to +-output_limit. The derivative term is used only when time_step
// is above 0.0001 s. A clear request (action 1) zeroes the integral and the
// previous error and returns 0. A short microcode program steps one shared
// bit-serial multiply/divide unit, whose operations set the rate. One request
// is worked on at a time; a finished result waits in its own output register,
// so the next request is taken while it is unread. Configuration is written
// through a plain write port; the user must write it only while idle, as the
// block itself does not enforce it.
module pid_antiwindup_controller_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [DATA_WIDTH-1:0]               i_cfg_wdata,
    // request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_action,
    input  wire logic signed [DATA_WIDTH-1:0]        i_error_sample,
    input  wire logic [FRAC_BITS+7:0]                i_time_step,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [DATA_WIDTH-1:0]             o_control_output
);

    localparam int DW  = DATA_WIDTH;
    localparam int TSB = FRAC_BITS + 8;
    localparam int OPW = (DW > TSB) ? DW : TSB;
    localparam int YW  = OPW + 1;
    // largest time_step code that is still 0.0001 s or less
    localparam logic [TSB-1:0] DT_THRESH = TSB'((64'd1 << FRAC_BITS) / 64'd10000);

    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    // configuration registers
    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [DW-2:0]        r_int_lim, r_out_lim;

    // controller state and working registers
    logic signed [DW-1:0] r_integ, r_last;
    logic signed [DW-1:0] r_err, r_tmp, r_acc, r_out;
    logic [TSB-1:0]       r_dt;
    logic                 r_clear;

    pidaw_pkg::t_seq_ctl  ctl;
    pidaw_pkg::t_seq_stat stat;
    pidaw_pkg::t_unit_ctl unit_ctl;
    logic                 unit_done;
    logic signed [DW-1:0] unit_res;
    logic signed [DW-1:0] op_x;
    logic signed [YW-1:0] op_y;

    // saturating add and subtract at DATA_WIDTH
    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? S_MIN : S_MAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? S_MIN : S_MAX;
        end
        return s[DW-1:0];
    endfunction

    // symmetric clamp to +-lim
    function automatic logic signed [DW-1:0] clamp_sym(input logic signed [DW-1:0] v,
                                                       input logic [DW-2:0] lim);
        logic signed [DW:0] l;
        logic signed [DW:0] nl;
        logic signed [DW:0] ve;
        l  = $signed({2'b00, lim});
        nl = -l;
        ve = $signed({v[DW-1], v});
        if (ve > l) begin
            return l[DW-1:0];
        end
        if (ve < nl) begin
            return nl[DW-1:0];
        end
        return v;
    endfunction

    pidaw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    assign stat.unit_done = unit_done;
    assign stat.clear_req = r_clear;
    assign stat.short_dt  = (r_dt <= DT_THRESH);

    assign unit_ctl.start = ctl.unit_start;
    assign unit_ctl.op    = ctl.word.unit;

    // operand selection for the arithmetic unit
    always_comb begin
        case (ctl.word.xsel)
            pidaw_pkg::X_GAIN_P: op_x = r_gain_p;
            pidaw_pkg::X_GAIN_I: op_x = r_gain_i;
            pidaw_pkg::X_GAIN_D: op_x = r_gain_d;
            pidaw_pkg::X_TMP:    op_x = r_tmp;
            default:             op_x = r_err;
        endcase
        case (ctl.word.ysel)
            pidaw_pkg::Y_ERR:   op_y = YW'(r_err);
            pidaw_pkg::Y_INTEG: op_y = YW'(r_integ);
            pidaw_pkg::Y_TMP:   op_y = YW'(r_tmp);
            default:            op_y = $signed({{(YW-TSB){1'b0}}, r_dt});
        endcase
    end

    pidaw_arith #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (unit_ctl),
        .i_x      (op_x),
        .i_y      (op_y),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    // configuration registers and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= DW'(pidaw_pkg::GAIN_P_RESET);
            r_gain_i  <= DW'(pidaw_pkg::GAIN_I_RESET);
            r_gain_d  <= DW'(pidaw_pkg::GAIN_D_RESET);
            r_int_lim <= (DW-1)'(pidaw_pkg::INTEGRAL_LIMIT_RESET);
            r_out_lim <= (DW-1)'(pidaw_pkg::OUTPUT_LIMIT_RESET);
            r_integ   <= '0;
            r_last    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pidaw_pkg::CFG_GAIN_P:         r_gain_p  <= i_cfg_wdata;
                    pidaw_pkg::CFG_GAIN_I:         r_gain_i  <= i_cfg_wdata;
                    pidaw_pkg::CFG_GAIN_D:         r_gain_d  <= i_cfg_wdata;
                    pidaw_pkg::CFG_INTEGRAL_LIMIT: r_int_lim <= i_cfg_wdata[DW-2:0];
                    pidaw_pkg::CFG_OUTPUT_LIMIT:   r_out_lim <= i_cfg_wdata[DW-2:0];
                    default: ;  // ignore unused indexes
                endcase
            end
            if (ctl.exec) begin
                case (ctl.word.alu)
                    pidaw_pkg::ALU_INT_ADD:   r_integ <= sat_add(r_integ, unit_res);
                    pidaw_pkg::ALU_INT_CLAMP: r_integ <= clamp_sym(r_integ, r_int_lim);
                    pidaw_pkg::ALU_FINISH:    r_last  <= r_err;
                    pidaw_pkg::ALU_CLEAR: begin
                        r_integ <= '0;
                        r_last  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // request capture, working registers and output register
    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_clear <= i_action;
            r_err   <= i_error_sample;
            r_dt    <= i_time_step;
        end
        if (ctl.exec) begin
            case (ctl.word.alu)
                pidaw_pkg::ALU_ACC_LOAD: r_acc <= unit_res;
                pidaw_pkg::ALU_ACC_ADD:  r_acc <= sat_add(r_acc, unit_res);
                pidaw_pkg::ALU_DIFF:     r_tmp <= sat_sub(r_err, r_last);
                pidaw_pkg::ALU_TMP_LOAD: r_tmp <= unit_res;
                pidaw_pkg::ALU_FINISH:   r_acc <= clamp_sym(r_acc, r_out_lim);
                pidaw_pkg::ALU_CLEAR:    r_acc <= '0;
                default: ;
            endcase
        end
        // hold the result until the output slot is free
        if (ctl.load_out) begin
            r_out <= r_acc;
        end
    end

    assign o_control_output = r_out;

endmodule

`default_nettype wire

// File: test/tb_pid_antiwindup_controller_unit.sv
// Self-checking testbench for the PID controller: predicts every output and compares it.
`timescale 1ns / 1ps

module tb_pid_antiwindup_controller_unit;
    import pidaw_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int TS_W       = FRAC_BITS + 8;

    // Request actions
    localparam logic ACT_COMPUTE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Saturation bounds of a DATA_WIDTH signed value
    localparam longint SAT_HI      = 64'sd2147483647;
    localparam longint SAT_NEG_MAG = 64'sd2147483648;
    // Largest time step code that is still 0.0001 s or less
    localparam longint DT_MIN = (64'sd1 <<< FRAC_BITS) / 10000;

    localparam int IDLE_PCT      = 36;
    localparam int HOLD_AT       = 400;   // results seen before the long hold-off
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 105;
    localparam int TAIL_CYCLES   = 300;   // above one full compute with derivative

    // Predicts each control output from the requests the block has taken and
    // holds the outputs still owed by the block, oldest first.
    class pid_step_predictor;
        logic signed [DATA_WIDTH-1:0] gain_p, gain_i, gain_d;
        logic [DATA_WIDTH-2:0]        integ_lim, out_lim;
        longint                       integ, prev_err;
        logic signed [DATA_WIDTH-1:0] expected_outputs[$];
        int                           mismatches;

        function new();
            gain_p     = GAIN_P_RESET;
            gain_i     = GAIN_I_RESET;
            gain_d     = GAIN_D_RESET;
            integ_lim  = INTEGRAL_LIMIT_RESET;
            out_lim    = OUTPUT_LIMIT_RESET;
            integ      = 0;
            prev_err   = 0;
            mismatches = 0;
        endfunction

        function longint sat(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < -SAT_NEG_MAG) return -SAT_NEG_MAG;
            return v;
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Exact product, shifted down, truncated toward zero, then saturated
        function longint fix_mul(longint a, longint b);
            longint ma, mb, m, lim;
            bit     neg;
            neg = (a < 0) != (b < 0);
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            m   = (ma * mb) >>> FRAC_BITS;
            lim = neg ? SAT_NEG_MAG : SAT_HI;
            if (m > lim) m = lim;
            return neg ? -m : m;
        endfunction

        // (x << FRAC_BITS) / dt, truncated toward zero, then saturated; dt > 0
        function longint fix_div(longint x, longint dt);
            longint mx, q, lim;
            bit     neg;
            neg = x < 0;
            mx  = neg ? -x : x;
            q   = (mx <<< FRAC_BITS) / dt;
            lim = neg ? SAT_NEG_MAG : SAT_HI;
            if (q > lim) q = lim;
            return neg ? -q : q;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] val);
            case (idx)
                CFG_GAIN_P:         gain_p    = val;
                CFG_GAIN_I:         gain_i    = val;
                CFG_GAIN_D:         gain_d    = val;
                CFG_INTEGRAL_LIMIT: integ_lim = val[DATA_WIDTH-2:0];
                CFG_OUTPUT_LIMIT:   out_lim   = val[DATA_WIDTH-2:0];
                default: ;
            endcase
        endfunction

        function void take_request(logic act, logic signed [DATA_WIDTH-1:0] err,
                                   logic [TS_W-1:0] dt);
            longint e, step, p_term, i_term, d_term, total;
            if (act == ACT_CLEAR) begin
                integ    = 0;
                prev_err = 0;
                expected_outputs.push_back('0);
                return;
            end
            e    = longint'(err);
            step = longint'(dt);
            integ = clamp_sym(sat(integ + fix_mul(e, step)), longint'(integ_lim));
            p_term = fix_mul(longint'(gain_p), e);
            i_term = fix_mul(longint'(gain_i), integ);
            // derivative only above 0.0001 s; error difference saturates
            d_term = 0;
            if (step > DT_MIN)
                d_term = fix_div(fix_mul(longint'(gain_d), sat(e - prev_err)), step);
            prev_err = e;
            total = clamp_sym(sat(sat(p_term + i_term) + d_term), longint'(out_lim));
            expected_outputs.push_back(total[DATA_WIDTH-1:0]);
        endfunction

        function void check_output(logic signed [DATA_WIDTH-1:0] got);
            logic signed [DATA_WIDTH-1:0] want;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output %0d (%h) with none pending", got, got);
                return;
            end
            want = expected_outputs.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output mismatch: expected %0d (%h), got %0d (%h)",
                             want, want, got, got);
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [DATA_WIDTH-1:0]        i_cfg_wdata;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_action;
    logic signed [DATA_WIDTH-1:0] i_error_sample;
    logic [TS_W-1:0]              i_time_step;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [DATA_WIDTH-1:0] o_control_output;

    pid_step_predictor book;
    bit                steady;        // no idling on either side while set
    int                results_seen;
    bit                hold_done;

    pid_antiwindup_controller_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_error_sample   (i_error_sample),
        .i_time_step      (i_time_step),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_control_output (o_control_output)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one request: idle at random first unless steady, then hold it until taken
    task automatic send_request(input logic act, input logic [DATA_WIDTH-1:0] err,
                                input logic [TS_W-1:0] dt);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_error_sample <= err;
        i_time_step    <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        book.take_request(act, err, dt);
    endtask

    // Drop valid and wait until every owed output has come back
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // Write one register; the enable stays high for back-to-back writes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_WIDTH-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        book.set_reg(idx, val);
    endtask

    // Write all five registers, plus an unused index when asked
    task automatic write_regs(input logic [DATA_WIDTH-1:0] gp, gi, gd, il, ol,
                              input bit stray);
        cfg_write(CFG_GAIN_P, gp);
        cfg_write(CFG_GAIN_I, gi);
        cfg_write(CFG_GAIN_D, gd);
        cfg_write(CFG_INTEGRAL_LIMIT, il);
        cfg_write(CFG_OUTPUT_LIMIT, ol);
        if (stray)
            cfg_write(CFG_OUTPUT_LIMIT + CFG_IDX_W'(1 + $urandom_range(2)), $urandom);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Gain within +-4.0
    function automatic logic [DATA_WIDTH-1:0] small_gain();
        return DATA_WIDTH'(int'($urandom_range(524288)) - 262144);
    endfunction

    task automatic apply_phase_settings(input int ph);
        logic [DATA_WIDTH-1:0] gp, gi, gd, il, ol;
        gp = small_gain();
        gi = small_gain();
        gd = small_gain();
        il = $urandom_range(1 << 22);
        ol = $urandom_range(1 << 22);
        case (ph)
            2: begin
                gp = $urandom;
                gi = $urandom;
                gd = $urandom;
                il = $urandom;
                ol = $urandom;
            end
            4: begin
                il = 32'h7FFF_FFFF;
                ol = 32'h7FFF_FFFF;
            end
            5: begin
                gp = 32'h8000_0000;
                gi = 32'h8000_0000;
                gd = 32'h8000_0000;
                il = $urandom_range(1 << 16);
                ol = $urandom_range(1 << 16);
            end
            6: begin
                gp = '0;
                gd = 32'h7FFF_FFFF;
            end
            7: begin
                gp = GAIN_P_RESET;
                gi = GAIN_I_RESET;
                gd = GAIN_D_RESET;
                il = INTEGRAL_LIMIT_RESET;
                ol = OUTPUT_LIMIT_RESET;
            end
            default: ;
        endcase
        write_regs(gp, gi, gd, il, ol, 1'($urandom_range(1)));
    endtask

    // Mostly small errors and realistic steps so the integral and output stay
    // off their clamps; the rest covers full range, extremes and tiny steps.
    task automatic send_random_request();
        logic                  act;
        logic [DATA_WIDTH-1:0] err;
        logic [TS_W-1:0]       dt;
        int                    pick;
        act  = ($urandom_range(99) < 7) ? ACT_CLEAR : ACT_COMPUTE;
        pick = $urandom_range(99);
        if (pick < 50)
            err = DATA_WIDTH'(int'($urandom_range(262144)) - 131072);
        else if (pick < 70)
            err = DATA_WIDTH'(int'($urandom_range(1 << 25)) - (1 << 24));
        else if (pick < 90)
            err = $urandom;
        else begin
            case ($urandom_range(4))
                0:       err = 32'h7FFF_FFFF;
                1:       err = 32'h8000_0000;
                2:       err = '0;
                3:       err = 32'h0000_0001;
                default: err = '1;
            endcase
        end
        pick = $urandom_range(99);
        if (pick < 40)
            dt = TS_W'($urandom_range(4000, 100));
        else if (pick < 55)
            dt = TS_W'($urandom_range(8));
        else if (pick < 80)
            dt = TS_W'($urandom);
        else if (pick < 90)
            dt = {TS_W{1'b1}} - TS_W'($urandom_range(3));
        else
            dt = TS_W'($urandom_range(1 << 16));
        send_request(act, err, dt);
    endtask

    // Result side: check every taken output, stall at random, and once hold
    // off long enough for the block to fill up and stall its request side.
    initial begin
        results_seen = 0;
        hold_done    = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                book.check_output(o_control_output);
                results_seen++;
            end
            if (!hold_done && results_seen == HOLD_AT) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        book   = new();
        steady = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= CFG_GAIN_P;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_action       <= ACT_COMPUTE;
        i_error_sample <= '0;
        i_time_step    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains: derivative threshold, zero step, error difference overflow
        send_request(ACT_COMPUTE, 32'h0001_0000, 24'd1311);
        send_request(ACT_COMPUTE, 32'h7FFF_FFFF, 24'd0);
        send_request(ACT_COMPUTE, 32'h8000_0000, 24'd7);
        send_request(ACT_COMPUTE, 32'h7FFF_FFFF, 24'hFF_FFFF);
        send_request(ACT_COMPUTE, 32'hFFFF_FFFF, 24'd6);
        send_request(ACT_CLEAR,   32'h1234_5678, 24'h00_0400);
        send_request(ACT_COMPUTE, 32'h0000_0000, 24'd1);
        finish_phase();

        // Largest gains; limit written with its top bit set to check masking
        write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 1'b1);
        send_request(ACT_COMPUTE, 32'h7FFF_FFFF, 24'hFF_FFFF);
        send_request(ACT_COMPUTE, 32'h8000_0000, 24'hFF_FFFF);
        send_request(ACT_COMPUTE, 32'h0000_0001, 24'd7);
        send_request(ACT_COMPUTE, 32'hFFFF_FFFF, 24'd1);
        send_request(ACT_CLEAR,   32'h8000_0000, 24'hFF_FFFF);
        send_request(ACT_COMPUTE, 32'h8000_0000, 24'h80_0000);
        finish_phase();

        // Zero limits force both integral and output to zero
        write_regs(32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                   32'h0000_0000, 1'b1);
        send_request(ACT_COMPUTE, 32'h1234_5678, 24'd1000);
        send_request(ACT_COMPUTE, 32'hEDCB_A988, 24'd7);
        send_request(ACT_CLEAR,   32'h0000_0000, 24'd0);
        finish_phase();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            steady = (ph == 0);
            apply_phase_settings(ph);
            repeat (PHASE_ITEMS) send_random_request();
            finish_phase();
        end
        steady = 1'b0;

        // Catch any stray output after the last one owed
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
